// ===== hw/rtl/jcs_pkg.sv =====
// Package for the JSON comment stripper: character codes, scan modes and
// the result item types shared by the scanner and the top level.
// No dependencies.
`default_nettype none

package jcs_pkg;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_STRING = 5'b00010,
        MODE_ESCAPE = 5'b00100,
        MODE_LINE   = 5'b01000,
        MODE_BLOCK  = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        logic       end_of_message;
        logic       end_of_run;
        logic       has_byte;
        logic [7:0] out_byte;
    } result_item_t;

    typedef struct packed {
        logic [1:0]   count;
        result_item_t item0;
        result_item_t item1;
    } scan_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jcs_scanner.sv =====
// Comment scanner: holds the scan mode and the pending slash and star, and
// turns one accepted byte into up to two result items.
// Depends on jcs_pkg.
`default_nettype none

module jcs_scanner (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    output jcs_pkg::scan_result_t      result
);

    jcs_pkg::scan_mode_t mode_reg, mode_next;
    logic                slash_reg, slash_next;
    logic                star_reg, star_next;

    logic [1:0] kept_count;
    logic [7:0] kept0;
    logic [7:0] kept1;

    always_comb begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        kept_count = 2'd0;
        kept0      = 8'h00;
        kept1      = 8'h00;

        case (mode_reg)
            jcs_pkg::MODE_STRING: begin
                kept_count = 2'd1;
                kept0      = in_byte;
                if (in_byte == jcs_pkg::CH_BACKSLASH) begin
                    mode_next = jcs_pkg::MODE_ESCAPE;
                end else if (in_byte == jcs_pkg::CH_QUOTE) begin
                    mode_next = jcs_pkg::MODE_NORMAL;
                end
            end
            jcs_pkg::MODE_ESCAPE: begin
                kept_count = 2'd1;
                kept0      = in_byte;
                mode_next  = jcs_pkg::MODE_STRING;
            end
            jcs_pkg::MODE_LINE: begin
                if (in_byte == jcs_pkg::CH_NEWLINE) begin
                    kept_count = 2'd1;
                    kept0      = in_byte;
                    mode_next  = jcs_pkg::MODE_NORMAL;
                end
            end
            jcs_pkg::MODE_BLOCK: begin
                if (star_reg && in_byte == jcs_pkg::CH_SLASH) begin
                    star_next = 1'b0;
                    mode_next = jcs_pkg::MODE_NORMAL;
                end else begin
                    star_next = (in_byte == jcs_pkg::CH_STAR);
                    if (in_byte == jcs_pkg::CH_NEWLINE) begin
                        kept_count = 2'd1;
                        kept0      = in_byte;
                    end
                end
            end
            default: begin
                if (slash_reg) begin
                    slash_next = 1'b0;
                    if (in_byte == jcs_pkg::CH_SLASH) begin
                        mode_next = jcs_pkg::MODE_LINE;
                    end else if (in_byte == jcs_pkg::CH_STAR) begin
                        mode_next = jcs_pkg::MODE_BLOCK;
                    end else begin
                        kept_count = 2'd2;
                        kept0      = jcs_pkg::CH_SLASH;
                        kept1      = in_byte;
                        if (in_byte == jcs_pkg::CH_QUOTE) begin
                            mode_next = jcs_pkg::MODE_STRING;
                        end
                    end
                end else if (in_byte == jcs_pkg::CH_SLASH) begin
                    slash_next = 1'b1;
                end else begin
                    kept_count = 2'd1;
                    kept0      = in_byte;
                    if (in_byte == jcs_pkg::CH_QUOTE) begin
                        mode_next = jcs_pkg::MODE_STRING;
                    end
                end
            end
        endcase

        // A slash still held at the end of a message is flushed as text.
        if (in_last && slash_next) begin
            kept_count = 2'd1;
            kept0      = jcs_pkg::CH_SLASH;
        end
    end

    always_comb begin
        result.item0.out_byte       = kept0;
        result.item0.has_byte       = (kept_count != 2'd0);
        result.item0.end_of_run     = (kept_count != 2'd2);
        result.item0.end_of_message = in_last && (kept_count != 2'd2);
        result.item1.out_byte       = kept1;
        result.item1.has_byte       = 1'b1;
        result.item1.end_of_run     = 1'b1;
        result.item1.end_of_message = in_last;
        if (kept_count == 2'd0 && in_last) begin
            result.count = 2'd1;
        end else begin
            result.count = kept_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= jcs_pkg::MODE_NORMAL;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end else if (accept) begin
            if (in_last) begin
                mode_reg  <= jcs_pkg::MODE_NORMAL;
                slash_reg <= 1'b0;
                star_reg  <= 1'b0;
            end else begin
                mode_reg  <= mode_next;
                slash_reg <= slash_next;
                star_reg  <= star_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/json_comment_stripper_core.sv =====
// Top level of the JSON comment stripper: stream ports, the scanner and a
// two-entry result queue that feeds the output channel.
// Depends on jcs_pkg and jcs_scanner.
//
// Channel  Dir  Payload
// s_       in   tdata = in_byte, tlast = in_last
// m_       out  tdata = out_byte, tuser = has_byte, end_of_run; tlast = end_of_message
//
// Each byte is scanned in the cycle it is accepted and its results are
// registered in the queue, so the first result shows in the next cycle.
// One item per cycle is taken while each gives at most one result and the
// output is not stalled; an item that gives two results (a held slash
// followed by text) keeps s_tready low while the queue drains.
// aresetn is synchronous and active low and clears the queue and scan state.
`default_nettype none

module json_comment_stripper_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] out_byte
    output      logic [1:0] m_tuser,   // [0] has_byte, [1] end_of_run
    output      logic       m_tlast
);

    jcs_pkg::scan_result_t result;
    jcs_pkg::result_item_t q0_reg, q0_next;
    jcs_pkg::result_item_t q1_reg, q1_next;
    logic [1:0]            count_reg, count_next;
    logic                  accept;
    logic                  pop;

    assign pop      = (count_reg != 2'd0) && m_tready;
    assign s_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);
    assign accept   = s_tvalid && s_tready;

    jcs_scanner u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .result  (result)
    );

    always_comb begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        if (accept) begin
            q0_next    = result.item0;
            q1_next    = result.item1;
            count_next = result.count;
        end else if (pop) begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = q0_reg.out_byte;
    assign m_tuser  = {q0_reg.end_of_run, q0_reg.has_byte};
    assign m_tlast  = q0_reg.end_of_message;

endmodule

`default_nettype wire

// ===== hw/rtl/jcs_checker.sv =====
// Port-level checks for the JSON comment stripper, bound to the top level.
// Depends on json_comment_stripper_core.
`default_nettype none

module jcs_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("Stalled result item changed.");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00 && m_tlast && m_tuser[1])
        else $error("Empty result item outside end of message.");

    a_eom_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("End of message without end of run.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind json_comment_stripper_core jcs_checker u_jcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/tb_json_comment_stripper_core.sv =====
`timescale 1ns / 1ps
// Testbench for json_comment_stripper_core: streams text messages through the
// stripper and checks every result item against a built-in comment stripper.
// Depends on jcs_pkg and the RTL of json_comment_stripper_core.

module tb_json_comment_stripper_core;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int TOTAL_ITEMS  = 1350;

    class strip_scoreboard;
        jcs_pkg::scan_mode_t   mode;
        bit                    slash_held;
        bit                    star_held;
        logic [7:0]            kept[$];
        jcs_pkg::result_item_t stripped_q[$];
        int                    errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            mode       = jcs_pkg::MODE_NORMAL;
            slash_held = 1'b0;
            star_held  = 1'b0;
        endfunction

        function void text_byte(logic [7:0] b);
            if (b == jcs_pkg::CH_SLASH) begin
                slash_held = 1'b1;
            end else begin
                if (b == jcs_pkg::CH_QUOTE) begin
                    mode = jcs_pkg::MODE_STRING;
                end
                kept = {kept, b};
            end
        endfunction

        function void note_input(logic [7:0] b, logic last);
            jcs_pkg::result_item_t r;
            kept.delete();
            case (mode)
                jcs_pkg::MODE_STRING: begin
                    kept = {kept, b};
                    if (b == jcs_pkg::CH_BACKSLASH) begin
                        mode = jcs_pkg::MODE_ESCAPE;
                    end else if (b == jcs_pkg::CH_QUOTE) begin
                        mode = jcs_pkg::MODE_NORMAL;
                    end
                end
                jcs_pkg::MODE_ESCAPE: begin
                    kept = {kept, b};
                    mode = jcs_pkg::MODE_STRING;
                end
                jcs_pkg::MODE_LINE: begin
                    if (b == jcs_pkg::CH_NEWLINE) begin
                        kept = {kept, b};
                        mode = jcs_pkg::MODE_NORMAL;
                    end
                end
                jcs_pkg::MODE_BLOCK: begin
                    if (star_held && b == jcs_pkg::CH_SLASH) begin
                        star_held = 1'b0;
                        mode = jcs_pkg::MODE_NORMAL;
                    end else begin
                        star_held = (b == jcs_pkg::CH_STAR);
                        if (b == jcs_pkg::CH_NEWLINE) begin
                            kept = {kept, b};
                        end
                    end
                end
                default: begin
                    if (slash_held) begin
                        slash_held = 1'b0;
                        if (b == jcs_pkg::CH_SLASH) begin
                            mode = jcs_pkg::MODE_LINE;
                        end else if (b == jcs_pkg::CH_STAR) begin
                            mode = jcs_pkg::MODE_BLOCK;
                        end else begin
                            kept = {kept, jcs_pkg::CH_SLASH};
                            text_byte(b);
                        end
                    end else begin
                        text_byte(b);
                    end
                end
            endcase
            if (last && slash_held) begin
                kept = {kept, jcs_pkg::CH_SLASH};
            end
            for (int k = 0; k < kept.size(); k++) begin
                r.out_byte       = kept[k];
                r.has_byte       = 1'b1;
                r.end_of_run     = (k == kept.size() - 1);
                r.end_of_message = last && (k == kept.size() - 1);
                stripped_q = {stripped_q, r};
            end
            if (last) begin
                if (kept.size() == 0) begin
                    r = '{end_of_message: 1'b1, end_of_run: 1'b1, has_byte: 1'b0,
                          out_byte: 8'h00};
                    stripped_q = {stripped_q, r};
                end
                clear_scan();
            end
        endfunction

        function void check_result(jcs_pkg::result_item_t got);
            jcs_pkg::result_item_t want;
            if (stripped_q.size() == 0) begin
                $error("unexpected result item: out_byte %h has_byte %b", got.out_byte,
                       got.has_byte);
                errors++;
                return;
            end
            want = stripped_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.has_byte !== want.has_byte) begin
                $error("has_byte: expected %b, actual %b", want.has_byte, got.has_byte);
                errors++;
            end
            if (got.end_of_run !== want.end_of_run) begin
                $error("end_of_run: expected %b, actual %b", want.end_of_run, got.end_of_run);
                errors++;
            end
            if (got.end_of_message !== want.end_of_message) begin
                $error("end_of_message: expected %b, actual %b", want.end_of_message,
                       got.end_of_message);
                errors++;
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    strip_scoreboard       sb;
    jcs_pkg::result_item_t got_item;
    bit                    quiet = 1'b0;
    int                    items_sent = 0;
    int                    cycles = 0;
    int                    ready_stall = 0;

    json_comment_stripper_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got_item.out_byte       = m_tdata;
            got_item.has_byte       = m_tuser[0];
            got_item.end_of_run     = m_tuser[1];
            got_item.end_of_message = m_tlast;
            sb.check_result(got_item);
        end
    end

    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready <= 1'b1;
        end else if (ready_stall > 0) begin
            ready_stall = ready_stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            ready_stall = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Called just after a falling edge; returns just after the falling edge that follows the byte's acceptance.
    task automatic send_byte(logic [7:0] b, logic last);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(b, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(string s, bit last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], last && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] plain_char();
        if ($urandom_range(0, 5) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 6))
            0: return jcs_pkg::CH_SLASH;
            1: return jcs_pkg::CH_STAR;
            2: return jcs_pkg::CH_QUOTE;
            3: return jcs_pkg::CH_BACKSLASH;
            4: return jcs_pkg::CH_NEWLINE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds a message from text, comments, strings and noise, then sends it.
    task automatic send_message();
        logic [7:0] msg[$];
        int         frags;
        int         n;
        frags = $urandom_range(1, 6);
        for (int f = 0; f < frags; f++) begin
            n = $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat (n + 1) msg = {msg, plain_char()};
                end
                3: begin
                    msg = {msg, jcs_pkg::CH_SLASH};
                    msg = {msg, jcs_pkg::CH_SLASH};
                    repeat (n) msg = {msg, ($urandom_range(0, 3) == 0) ? noise_char()
                                                                       : plain_char()};
                    if ($urandom_range(0, 4) != 0) msg = {msg, jcs_pkg::CH_NEWLINE};
                end
                4: begin
                    msg = {msg, jcs_pkg::CH_SLASH};
                    msg = {msg, jcs_pkg::CH_STAR};
                    repeat (n) msg = {msg, ($urandom_range(0, 2) == 0) ? noise_char()
                                                                       : plain_char()};
                    if ($urandom_range(0, 4) != 0) begin
                        if ($urandom_range(0, 2) == 0) msg = {msg, jcs_pkg::CH_STAR};
                        msg = {msg, jcs_pkg::CH_STAR};
                        msg = {msg, jcs_pkg::CH_SLASH};
                    end
                end
                5: begin
                    msg = {msg, jcs_pkg::CH_QUOTE};
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0) begin
                            msg = {msg, jcs_pkg::CH_BACKSLASH};
                            msg = {msg, noise_char()};
                        end else begin
                            msg = {msg, plain_char()};
                        end
                    end
                    if ($urandom_range(0, 4) != 0) msg = {msg, jcs_pkg::CH_QUOTE};
                end
                6: begin
                    msg = {msg, jcs_pkg::CH_SLASH};
                    msg = {msg, ($urandom_range(0, 3) == 0) ? jcs_pkg::CH_QUOTE
                                                            : plain_char()};
                end
                7, 8: begin
                    repeat (n + 1) msg = {msg, noise_char()};
                end
                default: begin
                    repeat (n + 1) msg = {msg, 8'($urandom_range(0, 255))};
                end
            endcase
        end
        for (int i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_text("a", 1'b1);
        send_text("/", 1'b1);
        send_text("/b", 1'b1);
        send_text("/\"", 1'b1);
        send_text("//x\ny", 1'b1);
        send_text("/*\n*a**/", 1'b1);
        send_text("\"\\\"/\"", 1'b1);
        send_text("//", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        while (items_sent < RANDOM_ITEMS) send_message();
        quiet = 1'b1;
        while (items_sent < TOTAL_ITEMS) send_message();
        s_tvalid <= 1'b0;

        while (sb.stripped_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/jcs_pkg.sv
hw/rtl/jcs_scanner.sv
hw/rtl/json_comment_stripper_core.sv
hw/rtl/jcs_checker.sv
sim/tb_json_comment_stripper_core.sv
